### hw/rtl/hbs_pkg.sv
// Shared constants for the heightmap bilinear sampler: field widths,
// item kinds and configuration register indices.
// No dependencies.
`default_nettype none

package hbs_pkg;

    localparam int POS_W    = 20;
    localparam int INV_W    = 24;
    localparam int GRID_W   = 7;
    localparam int CORNER_W = 7;
    localparam int HEIGHT_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_INV_TILE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH    = 2'd2;

    localparam logic [INV_W-1:0]  INV_TILE_RESET = 24'd65536;
    localparam logic [GRID_W-1:0] GRID_RESET     = 7'd64;

endpackage

`default_nettype wire

### hw/rtl/heightmap_bilinear_sampler.sv
// Top level of the heightmap bilinear sampler: corner height store in four
// parity banks and a four-stage query pipeline.
// Depends on hbs_pkg.
`default_nettype none

// One item is taken in every clock cycle; busy never rises. A query gives its
// height with done high for one cycle, starting at the third rising edge after
// the edge that accepted it, and the receiver must take it then. A corner write
// gives no result and is seen by every query accepted in a later cycle. The
// store is split by the parity of column and row into four banks, each with one
// write and one read port, so the four corners of a cell are read in the same
// cycle. Heights of corners that were never written are undefined.
module heightmap_bilinear_sampler #(
    parameter int MAX_GRID_SIDE = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic                                  kind,
    input  wire logic signed [hbs_pkg::POS_W-1:0]      pos_x,
    input  wire logic signed [hbs_pkg::POS_W-1:0]      pos_z,
    input  wire logic        [hbs_pkg::CORNER_W-1:0]   corner_x,
    input  wire logic        [hbs_pkg::CORNER_W-1:0]   corner_z,
    input  wire logic signed [hbs_pkg::HEIGHT_W-1:0]   corner_height,
    output logic                                       done,
    output logic signed [hbs_pkg::HEIGHT_W-1:0]        height,
    input  wire logic                                  cfg_wen,
    input  wire logic        [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [hbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import hbs_pkg::*;

    localparam int SIDE_W     = $clog2(MAX_GRID_SIDE + 1);
    localparam int HALF       = MAX_GRID_SIDE / 2 + 1;
    localparam int HALF_W     = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int PROD_W     = POS_W + INV_W + 1;

    // Configuration registers
    logic [INV_W-1:0]  inv_tile_size_reg;
    logic [GRID_W-1:0] grid_width_reg;
    logic [GRID_W-1:0] grid_depth_reg;

    // Stage 1: scaled positions and write fields
    logic                       s1_valid_reg;
    logic                       s1_kind_reg;
    logic signed [PROD_W-1:0]   s1_prod_x_reg;
    logic signed [PROD_W-1:0]   s1_prod_z_reg;
    logic [CORNER_W-1:0]        s1_cx_reg;
    logic [CORNER_W-1:0]        s1_cz_reg;
    logic signed [HEIGHT_W-1:0] s1_ch_reg;

    // Stage 2: fractions and corner parities, bank read data
    logic        s2_valid_reg;
    logic [15:0] s2_fx_reg;
    logic [15:0] s2_fz_reg;
    logic        s2_x0p_reg;
    logic        s2_x1p_reg;
    logic        s2_z0p_reg;
    logic        s2_z1p_reg;
    logic signed [HEIGHT_W-1:0] bank_rd_reg [4];

    // Stage 3: blended rows
    logic               s3_valid_reg;
    logic [15:0]        s3_fz_reg;
    logic signed [31:0] s3_h0_reg;
    logic signed [31:0] s3_h1_reg;

    // Output
    logic                       done_reg;
    logic signed [HEIGHT_W-1:0] height_reg;

    function automatic logic [SIDE_W-1:0] grid_limit(input logic [GRID_W-1:0] g);
        logic [SIDE_W-1:0] r;
        if (g == '0) begin
            r = SIDE_W'(1);
        end else if (int'(g) > MAX_GRID_SIDE) begin
            r = SIDE_W'(MAX_GRID_SIDE);
        end else begin
            r = SIDE_W'(g);
        end
        return r;
    endfunction

    function automatic logic [SIDE_W-1:0] clamp_idx(
        input logic signed [POS_W:0] c,
        input logic [SIDE_W-1:0]     g
    );
        logic [SIDE_W-1:0] r;
        if (c < 0) begin
            r = '0;
        end else if (c > $signed({{(POS_W + 1 - SIDE_W){1'b0}}, g})) begin
            r = g;
        end else begin
            r = SIDE_W'(c);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] bank_addr(
        input logic [HALF_W-1:0] xh,
        input logic [HALF_W-1:0] zh
    );
        return ADDR_W'(xh) * ADDR_W'(HALF) + ADDR_W'(zh);
    endfunction

    assign busy = 1'b0;

    // Configuration and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_tile_size_reg <= INV_TILE_RESET;
            grid_width_reg    <= GRID_RESET;
            grid_depth_reg    <= GRID_RESET;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_INV_TILE_SIZE: inv_tile_size_reg <= cfg_wdata[INV_W-1:0];
                    REG_GRID_WIDTH:    grid_width_reg    <= cfg_wdata[GRID_W-1:0];
                    REG_GRID_DEPTH:    grid_depth_reg    <= cfg_wdata[GRID_W-1:0];
                    default: ;
                endcase
            end
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg && (s1_kind_reg == KIND_QUERY);
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    // Stage 1: scale the position by the reciprocal tile size
    always_ff @(posedge clk)
    begin
        s1_kind_reg   <= kind;
        s1_prod_x_reg <= pos_x * $signed({1'b0, inv_tile_size_reg});
        s1_prod_z_reg <= pos_z * $signed({1'b0, inv_tile_size_reg});
        s1_cx_reg     <= corner_x;
        s1_cz_reg     <= corner_z;
        s1_ch_reg     <= corner_height;
    end

    // Cell split and corner clamping
    logic signed [POS_W-1:0] cell_x, cell_z;
    logic signed [POS_W:0]   cell_x0, cell_x1, cell_z0, cell_z1;
    logic [SIDE_W-1:0]       gw, gd, x0, x1, z0, z1;

    always_comb
    begin
        gw      = grid_limit(grid_width_reg);
        gd      = grid_limit(grid_depth_reg);
        cell_x  = s1_prod_x_reg[POS_W+23:24];
        cell_z  = s1_prod_z_reg[POS_W+23:24];
        cell_x0 = (POS_W + 1)'(cell_x);
        cell_z0 = (POS_W + 1)'(cell_z);
        cell_x1 = cell_x0 + $signed((POS_W + 1)'(1));
        cell_z1 = cell_z0 + $signed((POS_W + 1)'(1));
        x0      = clamp_idx(cell_x0, gw);
        x1      = clamp_idx(cell_x1, gw);
        z0      = clamp_idx(cell_z0, gd);
        z1      = clamp_idx(cell_z1, gd);
    end

    // Each bank serves the corner whose column and row parities match it. When
    // both corners clamp to the same edge only one of the two banks is used.
    logic              wr_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr [4];
    logic [3:0]        wr_en;

    always_comb
    begin
        wr_ok   = s1_valid_reg && (s1_kind_reg == KIND_WRITE)
                  && (int'(s1_cx_reg) <= MAX_GRID_SIDE)
                  && (int'(s1_cz_reg) <= MAX_GRID_SIDE);
        wr_addr = bank_addr(HALF_W'(s1_cx_reg >> 1), HALF_W'(s1_cz_reg >> 1));
        for (int b = 0; b < 4; b++)
        begin
            wr_en[b]   = wr_ok && (s1_cx_reg[0] == b[1]) && (s1_cz_reg[0] == b[0]);
            rd_addr[b] = bank_addr(HALF_W'(((x0[0] == b[1]) ? x0 : x1) >> 1),
                                   HALF_W'(((z0[0] == b[0]) ? z0 : z1) >> 1));
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic signed [HEIGHT_W-1:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en[b])
            begin
                mem[wr_addr] <= s1_ch_reg;
            end
            bank_rd_reg[b] <= mem[rd_addr[b]];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_fx_reg  <= s1_prod_x_reg[23:8];
        s2_fz_reg  <= s1_prod_z_reg[23:8];
        s2_x0p_reg <= x0[0];
        s2_x1p_reg <= x1[0];
        s2_z0p_reg <= z0[0];
        s2_z1p_reg <= z1[0];
    end

    // Stage 2: blend along x
    logic signed [HEIGHT_W-1:0] h00, h10, h01, h11;
    logic signed [HEIGHT_W:0]   dx0, dx1;
    logic signed [33:0]         px0, px1, h0_sum, h1_sum;

    always_comb
    begin
        h00    = bank_rd_reg[{s2_x0p_reg, s2_z0p_reg}];
        h10    = bank_rd_reg[{s2_x1p_reg, s2_z0p_reg}];
        h01    = bank_rd_reg[{s2_x0p_reg, s2_z1p_reg}];
        h11    = bank_rd_reg[{s2_x1p_reg, s2_z1p_reg}];
        dx0    = (HEIGHT_W + 1)'(h10) - (HEIGHT_W + 1)'(h00);
        dx1    = (HEIGHT_W + 1)'(h11) - (HEIGHT_W + 1)'(h01);
        px0    = dx0 * $signed({1'b0, s2_fx_reg});
        px1    = dx1 * $signed({1'b0, s2_fx_reg});
        h0_sum = $signed({{2{h00[HEIGHT_W-1]}}, h00, 16'h0000}) + px0;
        h1_sum = $signed({{2{h01[HEIGHT_W-1]}}, h01, 16'h0000}) + px1;
    end

    // Each row blend lies between its two corners and fits in 32 bits.
    always_ff @(posedge clk)
    begin
        s3_fz_reg <= s2_fz_reg;
        s3_h0_reg <= h0_sum[31:0];
        s3_h1_reg <= h1_sum[31:0];
    end

    // Stage 3: blend along z and round half upward
    logic signed [32:0] dz;
    logic signed [49:0] pz, v_sum, v_round;

    always_comb
    begin
        dz      = $signed({s3_h1_reg[31], s3_h1_reg}) - $signed({s3_h0_reg[31], s3_h0_reg});
        pz      = dz * $signed({1'b0, s3_fz_reg});
        v_sum   = $signed({{2{s3_h0_reg[31]}}, s3_h0_reg, 16'h0000}) + pz;
        v_round = v_sum + $signed(50'h0_0000_8000_0000);
    end

    always_ff @(posedge clk)
    begin
        height_reg <= v_round[47:32];
    end

    assign done   = done_reg;
    assign height = height_reg;

endmodule

`default_nettype wire
